FILE: rtl/core/lhc_pkg.sv
// ============================================================================
// lhc_pkg: shared types and constants of the handle cache
// Entry layout, request and response payloads, and memory command bundle.
// ============================================================================
package lhc_pkg;

    localparam int ENTRIES    = 32;
    localparam int STAMP_BITS = 32;
    localparam int IDX_W      = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int OCC_W      = 6;
    localparam int HND_W      = 16;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;

    localparam logic [ENTRIES-1:0] BIT0_MASK = ENTRIES'(1);

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       source_id;
        logic [7:0]       face_index;
        logic [31:0]      size_bits;
        logic [31:0]      style_flags;
        logic [HND_W-1:0] new_handle;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [HND_W-1:0] found_handle;
        logic             released_valid;
        logic [HND_W-1:0] released_handle;
        logic [OCC_W-1:0] occupied;
        logic             last;
    } t_rsp;

    typedef struct packed {
        logic [7:0]            source;
        logic [7:0]            face;
        logic [31:0]           size;
        logic [31:0]           style;
        logic [HND_W-1:0]      handle;
        logic [STAMP_BITS-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        t_entry           wr_data;
    } t_mem_cmd;

endpackage

FILE: rtl/core/lhc_ifs.sv
// ============================================================================
// lhc_ifs: request and response channels
// Valid/ready channels carrying the cache request and response payloads.
// ============================================================================
interface lhc_req_if;
    logic          valid;
    logic          ready;
    lhc_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lhc_rsp_if;
    logic          valid;
    logic          ready;
    lhc_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/lhc_store.sv
// ============================================================================
// lhc_store: entry memory
// One write port and one read port with registered read data.
// ============================================================================
module lhc_store (
    input  logic              i_clk,
    input  lhc_pkg::t_mem_cmd i_cmd,
    output lhc_pkg::t_entry   o_rd_data
);

    lhc_pkg::t_entry r_mem [lhc_pkg::ENTRIES];
    lhc_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/lhc_ctrl.sv
// ============================================================================
// lhc_ctrl: scan sequencer
// Walks the entry memory one slot per cycle, except while a flush waits on a
// full output register, for lookup, insert and flush, keeps valid bits,
// occupancy and the use clock, and drives the response.
module lhc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lhc_req_if.sink           i_req,
    lhc_rsp_if.source         o_rsp,
    output lhc_pkg::t_mem_cmd o_mem,
    input  lhc_pkg::t_entry   i_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    lhc_pkg::t_req                      r_req, n_req;
    logic [lhc_pkg::IDX_W:0]            r_ra, n_ra;
    logic                               r_dv, n_dv;
    logic [lhc_pkg::IDX_W-1:0]          r_di, n_di;
    logic [lhc_pkg::ENTRIES-1:0]        r_valid, n_valid;
    logic [lhc_pkg::CNT_W-1:0]          r_count, n_count;
    logic [lhc_pkg::STAMP_BITS-1:0]     r_clock, n_clock;
    logic                               r_have_min, n_have_min;
    logic [lhc_pkg::STAMP_BITS-1:0]     r_min, n_min;
    logic [lhc_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [lhc_pkg::HND_W-1:0]          r_hnd, n_hnd;
    logic                               r_hit, n_hit;
    logic                               r_rel, n_rel;
    logic                               r_empty, n_empty;
    logic                               r_ov, n_ov;
    lhc_pkg::t_rsp                      r_out, n_out;

    logic                               can_emit;
    logic                               d_last;
    logic                               cur_valid;
    logic                               key_eq;
    logic                               take_min;
    logic                               stall;
    logic [lhc_pkg::ENTRIES-1:0]        clr_mask;
    logic [lhc_pkg::CNT_W-1:0]          cnt_next;

    always_comb begin
        can_emit  = !r_ov || o_rsp.ready;
        d_last    = (r_di == lhc_pkg::IDX_W'(lhc_pkg::ENTRIES - 1));
        cur_valid = r_valid[r_di];
        key_eq    = (i_rd_data.source == r_req.source_id)
                 && (i_rd_data.face == r_req.face_index)
                 && (i_rd_data.size == r_req.size_bits)
                 && (i_rd_data.style == r_req.style_flags);
        take_min  = !r_have_min || (i_rd_data.stamp < r_min);
        clr_mask  = r_valid & ~(lhc_pkg::BIT0_MASK << r_di);
        stall     = r_dv && (r_req.kind == lhc_pkg::KIND_FLUSH) && cur_valid && !can_emit;
        cnt_next  = r_count + lhc_pkg::CNT_W'(r_empty);

        n_state    = r_state;
        n_req      = r_req;
        n_ra       = r_ra;
        n_dv       = r_dv;
        n_di       = r_di;
        n_valid    = r_valid;
        n_count    = r_count;
        n_clock    = r_clock;
        n_have_min = r_have_min;
        n_min      = r_min;
        n_idx      = r_idx;
        n_hnd      = r_hnd;
        n_hit      = r_hit;
        n_rel      = r_rel;
        n_empty    = r_empty;
        n_ov       = r_ov && !o_rsp.ready;
        n_out      = r_out;

        o_mem                 = '0;
        o_mem.wr_addr         = r_idx;
        o_mem.wr_data.source  = r_req.source_id;
        o_mem.wr_data.face    = r_req.face_index;
        o_mem.wr_data.size    = r_req.size_bits;
        o_mem.wr_data.style   = r_req.style_flags;
        o_mem.wr_data.handle  = (r_req.kind == lhc_pkg::KIND_INSERT) ? r_req.new_handle : r_hnd;
        o_mem.wr_data.stamp   = r_clock + lhc_pkg::STAMP_BITS'(1);

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_req      = i_req.data;
                    n_ra       = '0;
                    n_dv       = 1'b0;
                    n_have_min = 1'b0;
                    n_hit      = 1'b0;
                    n_rel      = 1'b0;
                    n_empty    = 1'b0;
                    case (i_req.data.kind)
                        lhc_pkg::KIND_LOOKUP, lhc_pkg::KIND_INSERT,
                        lhc_pkg::KIND_FLUSH: n_state = S_SCAN;
                        default:             n_state = S_FIN;
                    endcase
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    n_di = r_ra[lhc_pkg::IDX_W-1:0];
                    if (r_ra < (lhc_pkg::IDX_W + 1)'(lhc_pkg::ENTRIES)) begin
                        o_mem.rd_en   = 1'b1;
                        o_mem.rd_addr = r_ra[lhc_pkg::IDX_W-1:0];
                        n_ra          = r_ra + (lhc_pkg::IDX_W + 1)'(1);
                        n_dv          = 1'b1;
                    end else begin
                        n_dv = 1'b0;
                    end
                end
                if (r_dv) begin
                    case (r_req.kind)
                        lhc_pkg::KIND_LOOKUP: begin
                            if (cur_valid && key_eq) begin
                                n_hit   = 1'b1;
                                n_hnd   = i_rd_data.handle;
                                n_idx   = r_di;
                                n_state = S_FIN;
                            end else if (d_last) begin
                                n_state = S_FIN;
                            end
                        end
                        lhc_pkg::KIND_INSERT: begin
                            if (!cur_valid) begin
                                n_empty = 1'b1;
                                n_idx   = r_di;
                                n_state = S_FIN;
                            end else begin
                                if (take_min) begin
                                    n_have_min = 1'b1;
                                    n_min      = i_rd_data.stamp;
                                    n_idx      = r_di;
                                    n_hnd      = i_rd_data.handle;
                                end
                                if (d_last) begin
                                    n_rel   = 1'b1;
                                    n_state = S_FIN;
                                end
                            end
                        end
                        lhc_pkg::KIND_FLUSH: begin
                            if (cur_valid) begin
                                if (can_emit) begin
                                    n_ov                  = 1'b1;
                                    n_out                 = '0;
                                    n_out.released_valid  = 1'b1;
                                    n_out.released_handle = i_rd_data.handle;
                                    n_out.last            = (clr_mask == '0);
                                    n_valid               = clr_mask;
                                    if (clr_mask == '0) begin
                                        n_count = '0;
                                        n_state = S_IDLE;
                                    end
                                end
                            end else if (d_last) begin
                                n_state = S_FIN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_FIN: begin
                if (can_emit) begin
                    if ((r_req.kind == lhc_pkg::KIND_INSERT) || r_hit) begin
                        o_mem.wr_en    = 1'b1;
                        n_clock        = r_clock + lhc_pkg::STAMP_BITS'(1);
                        n_valid[r_idx] = 1'b1;
                    end
                    n_count               = cnt_next;
                    n_ov                  = 1'b1;
                    n_out.hit             = r_hit;
                    n_out.found_handle    = r_hit ? r_hnd : '0;
                    n_out.released_valid  = r_rel;
                    n_out.released_handle = r_rel ? r_hnd : '0;
                    n_out.occupied        = lhc_pkg::OCC_W'(cnt_next);
                    n_out.last            = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_clock <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            r_clock <= n_clock;
            r_ov    <= n_ov;
        end
        r_req      <= n_req;
        r_ra       <= n_ra;
        r_dv       <= n_dv;
        r_di       <= n_di;
        r_have_min <= n_have_min;
        r_min      <= n_min;
        r_idx      <= n_idx;
        r_hnd      <= n_hnd;
        r_hit      <= n_hit;
        r_rel      <= n_rel;
        r_empty    <= n_empty;
        r_out      <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

`ifndef SYNTH
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count == lhc_pkg::CNT_W'($countones(r_valid))))
        else $error("occupancy count disagrees with valid bits");

    a_last_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_ov && n_out.last && (r_state != S_IDLE) && can_emit) |=> (r_state == S_IDLE))
        else $error("final response did not end the request");

    a_evict_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_rel) |-> (&r_valid))
        else $error("eviction while an empty slot exists");

    a_hit_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && r_hit) |-> r_valid[r_idx])
        else $error("hit reported on an invalid slot");
`endif

endmodule

FILE: rtl/core/lru_handle_cache.sv
// ============================================================================
// lru_handle_cache: fully associative handle cache with LRU replacement
// ----------------------------------------------------------------------------
// Requests arrive on i_req and responses leave on o_rsp, both valid/ready.
// A request is a lookup, an insert or a flush; any other kind is answered
// with the current occupancy and changes nothing. Each lookup, insert or
// flush walks the 32-entry memory one slot per cycle through its single
// read port, except while a flush waits on the output register. A lookup
// stops at the first matching slot, an insert at the first empty slot or,
// with none empty, after the last, replacing the least recently used one.
// Stamp and entry write-back happen in the cycle that loads the response
// into the output register. A flush sends one response per released handle
// as the walk passes it, or one empty response if no slot is valid.
// One request is in flight at a time; the next is taken once the previous
// one has issued its last response, even while that response still waits
// in the output register. A stalled receiver holds the walk of a flush and
// the finishing step of any other request until the output register frees.
// Reset clears all valid bits, the occupancy count and the use clock at once.
// ============================================================================
module lru_handle_cache (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lhc_req_if.sink   i_req,
    lhc_rsp_if.source o_rsp
);

    lhc_pkg::t_mem_cmd mem_cmd;
    lhc_pkg::t_entry   rd_data;

    lhc_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (mem_cmd),
        .o_rd_data (rd_data)
    );

    lhc_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem     (mem_cmd),
        .i_rd_data (rd_data)
    );

endmodule

FILE: sim/lru_handle_cache_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// lru_handle_cache_tb: self-checking bench for the LRU handle cache
// A directed table covers empty, duplicate, near-miss, unused-kind and
// flush cases, then random lookup, insert, flush and unused-kind traffic
// runs over a shared key pool. A shadow copy of the cache predicts each
// response the table omits; channels idle at random in two of three phases.
// ============================================================================
module lru_handle_cache_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         RANDOM_REQS = 350;
    localparam int         POOL_KEYS   = 40;

    typedef struct packed {
        logic [7:0]  src;
        logic [7:0]  face;
        logic [31:0] size;
        logic [31:0] style;
    } t_cache_key;

    typedef struct {
        lhc_pkg::t_req req;
        bit            typed;
        lhc_pkg::t_rsp want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    lhc_req_if req_ch ();
    lhc_rsp_if rsp_ch ();

    lru_handle_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lhc_pkg::t_entry                shadow_slot [lhc_pkg::ENTRIES];
    bit                             slot_live   [lhc_pkg::ENTRIES];
    logic [lhc_pkg::STAMP_BITS-1:0] use_clock;

    lhc_pkg::t_rsp step_answers [$];
    lhc_pkg::t_rsp answers_due  [$];
    t_stim_row     directed_rows[$];
    t_cache_key    key_pool     [POOL_KEYS];

    int send_idle_pct;
    int recv_idle_pct;
    int errors;
    int n_lookups, n_hits, n_inserts, n_evictions, n_flushes, n_released, n_unused;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [lhc_pkg::OCC_W-1:0] occupancy();
        int n;
        n = 0;
        for (int i = 0; i < lhc_pkg::ENTRIES; i++) begin
            if (slot_live[i]) n++;
        end
        return lhc_pkg::OCC_W'(n);
    endfunction

    function automatic void predict_request(input lhc_pkg::t_req r);
        int            slot;
        bit            found_empty;
        lhc_pkg::t_rsp a;
        step_answers.delete();
        a = '0;
        a.last = 1'b1;
        slot = -1;
        found_empty = 1'b0;
        case (r.kind)
            lhc_pkg::KIND_LOOKUP: begin
                n_lookups++;
                for (int i = 0; i < lhc_pkg::ENTRIES; i++) begin
                    if (slot < 0 && slot_live[i] && shadow_slot[i].source == r.source_id
                        && shadow_slot[i].face == r.face_index
                        && shadow_slot[i].size == r.size_bits
                        && shadow_slot[i].style == r.style_flags) begin
                        slot = i;
                    end
                end
                if (slot >= 0) begin
                    use_clock = use_clock + lhc_pkg::STAMP_BITS'(1);
                    shadow_slot[slot].stamp = use_clock;
                    a.hit = 1'b1;
                    a.found_handle = shadow_slot[slot].handle;
                    n_hits++;
                end
                a.occupied = occupancy();
                step_answers.push_back(a);
            end
            lhc_pkg::KIND_INSERT: begin
                n_inserts++;
                for (int i = 0; i < lhc_pkg::ENTRIES; i++) begin
                    if (!slot_live[i]) begin
                        slot = i;
                        found_empty = 1'b1;
                        break;
                    end
                    if (slot < 0 || shadow_slot[i].stamp < shadow_slot[slot].stamp) slot = i;
                end
                if (!found_empty) begin
                    a.released_valid = 1'b1;
                    a.released_handle = shadow_slot[slot].handle;
                    n_evictions++;
                end
                use_clock = use_clock + lhc_pkg::STAMP_BITS'(1);
                slot_live[slot] = 1'b1;
                shadow_slot[slot].source = r.source_id;
                shadow_slot[slot].face = r.face_index;
                shadow_slot[slot].size = r.size_bits;
                shadow_slot[slot].style = r.style_flags;
                shadow_slot[slot].handle = r.new_handle;
                shadow_slot[slot].stamp = use_clock;
                a.occupied = occupancy();
                step_answers.push_back(a);
            end
            lhc_pkg::KIND_FLUSH: begin
                n_flushes++;
                for (int i = 0; i < lhc_pkg::ENTRIES; i++) begin
                    if (slot_live[i]) begin
                        slot_live[i] = 1'b0;
                        a = '0;
                        a.released_valid = 1'b1;
                        a.released_handle = shadow_slot[i].handle;
                        step_answers.push_back(a);
                        n_released++;
                    end
                end
                if (step_answers.size() == 0) begin
                    a = '0;
                    step_answers.push_back(a);
                end
                step_answers[step_answers.size() - 1].last = 1'b1;
            end
            default: begin
                n_unused++;
                a.occupied = occupancy();
                step_answers.push_back(a);
            end
        endcase
    endfunction

    function automatic void put_row(input logic [1:0] kind, input logic [7:0] src,
                                    input logic [7:0] face, input logic [31:0] size,
                                    input logic [31:0] style, input logic [15:0] hnd,
                                    input bit typed, input bit hit, input logic [15:0] found,
                                    input bit relv, input logic [15:0] relh,
                                    input logic [lhc_pkg::OCC_W-1:0] occ);
        t_stim_row row;
        row.req = '{kind, src, face, size, style, hnd};
        row.typed = typed;
        row.want = '{hit, found, relv, relh, occ, 1'b1};
        directed_rows.push_back(row);
    endfunction

    function automatic lhc_pkg::t_req make_request(input logic [1:0] kind,
                                                   input t_cache_key k,
                                                   input logic [15:0] hnd);
        lhc_pkg::t_req r;
        r = '{kind, k.src, k.face, k.size, k.style, hnd};
        return r;
    endfunction

    function automatic t_cache_key random_key();
        t_cache_key k;
        k = t_cache_key'({$urandom, $urandom, $urandom});
        return k;
    endfunction

    task automatic send_request(input lhc_pkg::t_req r, input bit typed,
                                input lhc_pkg::t_rsp want);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(r);
        if (typed) answers_due.push_back(want);
        else foreach (step_answers[i]) answers_due.push_back(step_answers[i]);
    endtask

    task automatic drain_answers();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    initial begin
        lhc_pkg::t_rsp want;
        lhc_pkg::t_rsp got;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.data;
                if (answers_due.size() == 0) begin
                    $display("%0t: response with none expected, expected nothing, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    report_field("hit", 32'(want.hit), 32'(got.hit));
                    report_field("found_handle", 32'(want.found_handle),
                                 32'(got.found_handle));
                    report_field("released_valid", 32'(want.released_valid),
                                 32'(got.released_valid));
                    report_field("released_handle", 32'(want.released_handle),
                                 32'(got.released_handle));
                    report_field("occupied", 32'(want.occupied), 32'(got.occupied));
                    report_field("last", 32'(want.last), 32'(got.last));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        t_cache_key    k;
        lhc_pkg::t_req r;
        int            pick;
        int            phase;
        int            step_phase;
        errors = 0;
        use_clock = '0;
        foreach (slot_live[i]) slot_live[i] = 1'b0;
        foreach (shadow_slot[i]) shadow_slot[i] = '0;
        send_idle_pct = 20;
        recv_idle_pct = 84;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_row(lhc_pkg::KIND_LOOKUP, 'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_FLUSH,  'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 0, 'h0, 0, 'h0, 0);
        put_row(KIND_UNUSED,          'hFF, 'hFF, 'hFFFFFFFF, 'hFFFFFFFF, 'hFFFF,
                1, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_INSERT, 'hFF, 'hFF, 'hFFFFFFFF, 'hFFFFFFFF, 'hFFFF,
                1, 0, 'h0, 0, 'h0, 1);
        put_row(lhc_pkg::KIND_INSERT, 'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 0, 'h0, 0, 'h0, 2);
        put_row(lhc_pkg::KIND_LOOKUP, 'hFF, 'hFF, 'hFFFFFFFF, 'hFFFFFFFF, 'h0000,
                1, 1, 'hFFFF, 0, 'h0, 2);
        put_row(lhc_pkg::KIND_LOOKUP, 'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 1, 'h0, 0, 'h0, 2);
        put_row(lhc_pkg::KIND_INSERT, 'h00, 'h00, 'h00000000, 'h00000000, 'h1234,
                1, 0, 'h0, 0, 'h0, 3);
        put_row(lhc_pkg::KIND_LOOKUP, 'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 1, 'h0, 0, 'h0, 3);
        put_row(lhc_pkg::KIND_INSERT, 'h01, 'h02, 'h00000000, 'hAAAAAAAA, 'h0101,
                1, 0, 'h0, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_LOOKUP, 'h01, 'h02, 'h80000000, 'hAAAAAAAA, 'h0000,
                1, 0, 'h0, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_LOOKUP, 'h01, 'h03, 'h00000000, 'hAAAAAAAA, 'h0000,
                1, 0, 'h0, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_LOOKUP, 'h02, 'h02, 'h00000000, 'hAAAAAAAA, 'h0000,
                1, 0, 'h0, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_LOOKUP, 'h01, 'h02, 'h00000000, 'hAAAAAAAB, 'h0000,
                1, 0, 'h0, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_LOOKUP, 'h01, 'h02, 'h00000000, 'hAAAAAAAA, 'h0000,
                1, 1, 'h0101, 0, 'h0, 4);
        put_row(lhc_pkg::KIND_INSERT, 'hAA, 'h55, 'h55555555, 'hAAAAAAAA, 'h5555,
                1, 0, 'h0, 0, 'h0, 5);
        put_row(KIND_UNUSED,          'h00, 'h00, 'h00000000, 'h00000000, 'h0000,
                1, 0, 'h0, 0, 'h0, 5);
        put_row(lhc_pkg::KIND_LOOKUP, 'hAA, 'h55, 'h55555555, 'hAAAAAAAA, 'hFFFF,
                0, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_FLUSH,  'h12, 'h34, 'h3F800000, 'h00000001, 'hBEEF,
                0, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_LOOKUP, 'hFF, 'hFF, 'hFFFFFFFF, 'hFFFFFFFF, 'h0000,
                1, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_INSERT, 'h7F, 'h80, 'h7F800000, 'h80000000, 'h8000,
                1, 0, 'h0, 0, 'h0, 1);
        put_row(lhc_pkg::KIND_LOOKUP, 'h7F, 'h80, 'h7F800000, 'h80000000, 'h0000,
                0, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_INSERT, 'h80, 'h7F, 'h7FC00000, 'h7FFFFFFF, 'h7FFF,
                0, 0, 'h0, 0, 'h0, 0);
        put_row(lhc_pkg::KIND_LOOKUP, 'h80, 'h7F, 'h7FC00000, 'h7FFFFFFF, 'h0000,
                0, 0, 'h0, 0, 'h0, 0);

        foreach (directed_rows[i]) begin
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        end
        drain_answers();

        for (int i = 0; i < POOL_KEYS; i++) begin
            if (i > 0 && $urandom_range(2) == 0) begin
                key_pool[i] = key_pool[i - 1] ^ (t_cache_key'(1) << $urandom_range(79));
            end else begin
                key_pool[i] = random_key();
            end
        end

        phase = 0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            step_phase = n * 3 / RANDOM_REQS;
            if (step_phase != phase) begin
                phase = step_phase;
                drain_answers();
                send_idle_pct = (phase == 1) ? 84 : 0;
                recv_idle_pct = (phase == 1) ? 20 : 0;
            end else if (n % 60 == 59) begin
                drain_answers();
            end
            pick = $urandom_range(999);
            k = key_pool[$urandom_range(POOL_KEYS - 1)];
            if (pick < 12) begin
                r = make_request(lhc_pkg::KIND_FLUSH, random_key(), 16'($urandom));
            end else if (pick < 30) begin
                r = make_request(KIND_UNUSED, random_key(), 16'($urandom));
            end else if (pick < 480) begin
                if ($urandom_range(9) == 0) k = random_key();
                r = make_request(lhc_pkg::KIND_INSERT, k, 16'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 8) k = random_key();
                else if (pick < 16) k = k ^ (t_cache_key'(1) << $urandom_range(79));
                r = make_request(lhc_pkg::KIND_LOOKUP, k, 16'($urandom));
            end
            send_request(r, 1'b0, '0);
        end

        drain_answers();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d lookups (%0d hits), %0d inserts (%0d evictions), %0d unused-kind",
                 n_lookups, n_hits, n_inserts, n_evictions, n_unused);
        $display("requests and %0d flushes that released %0d handles.", n_flushes, n_released);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/lhc_pkg.sv
rtl/core/lhc_ifs.sv
rtl/core/lhc_store.sv
rtl/core/lhc_ctrl.sv
rtl/core/lru_handle_cache.sv
sim/lru_handle_cache_tb.sv
